[hw/rtl/qgap_pkg.sv]
// Shared types and constants for the quantized global average pool.
// Used by the interfaces, the front, queue, back and top-level modules.
package qgap_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int SUM_W      = 32;
  localparam int CHANNELS_W = 11;
  localparam int KERNEL_W   = 25;
  localparam int SPATIAL_W  = 24;
  localparam int CHAN_OUT_W = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = KERNEL_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic [KERNEL_W-1:0] KERNEL_LIMIT = KERNEL_W'(1 << SPATIAL_W);

  localparam logic [CFG_INDEX_W-1:0] REG_IS_SIGNED    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_LAST = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPATIAL_SIZE = 8'd3;

  typedef struct packed {
    logic                  is_signed;
    logic                  channel_last;
    logic [CHANNELS_W-1:0] nc;
    logic [KERNEL_W-1:0]   k;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [CHAN_OUT_W-1:0] chan;
    logic                  image_done;
  } entry_t;

  typedef struct packed {
    logic room;
    logic nonempty;
  } queue_status_t;

endpackage

[hw/rtl/qgap_sample_if.sv]
// Input channel carrying one tensor element byte per item.
// Depends on qgap_pkg for the field width.
interface qgap_sample_if;
  logic                           valid;
  logic                           ready;
  logic [qgap_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[hw/rtl/qgap_result_if.sv]
// Output channel carrying one channel average per item.
// Depends on qgap_pkg for the field widths.
interface qgap_result_if;
  logic                            valid;
  logic                            ready;
  logic [qgap_pkg::SAMPLE_W-1:0]   average;
  logic [qgap_pkg::CHAN_OUT_W-1:0] channel_index;
  logic                            image_done;
  modport source (output valid, output average, output channel_index, output image_done,
                  input ready);
  modport sink (input valid, input average, input channel_index, input image_done,
                output ready);
endinterface

[hw/rtl/qgap_front.sv]
// Front part: accepts samples, tracks positions and accumulates channel sums.
// Uses qgap_pkg and qgap_sample_if; pushes finished sums into qgap_queue.
module qgap_front #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  qgap_pkg::cfg_t      cfg,
  input  logic                restart,
  qgap_sample_if.sink         samples,
  input  logic                queue_room,
  output logic                push,
  output qgap_pkg::entry_t    push_entry
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = qgap_pkg::CHANNELS_W;
  localparam int SW = qgap_pkg::SUM_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_ADD  = 1'b1;

  logic                            state;
  logic [qgap_pkg::SPATIAL_W-1:0]  spatial_position;
  logic [CW-1:0]                   channel_position;
  logic [SW-1:0]                   running_sum;
  logic [SW-1:0]                   x_hold;
  logic                            sp_zero;
  logic                            last_s;
  logic                            last_c;
  logic [CW-1:0]                   chan_hold;
  logic [AW-1:0]                   addr_hold;
  logic [SW-1:0]                   mem_q;
  logic [SW-1:0]                   sums [MAX_CHANNELS];

  logic          accept;
  logic [SW-1:0] x_ext;
  logic          last_s_now;
  logic          last_c_now;
  logic [AW-1:0] addr;
  logic [SW-1:0] base;
  logic [SW-1:0] sum;

  assign samples.ready = (state == S_IDLE) && queue_room;
  assign accept = samples.valid && samples.ready;

  assign x_ext = cfg.is_signed ? {{(SW-8){samples.sample[7]}}, samples.sample}
                               : {{(SW-8){1'b0}}, samples.sample};
  assign last_s_now = {1'b0, spatial_position} >= (cfg.k - 25'd1);
  assign last_c_now = channel_position >= (cfg.nc - 11'd1);
  assign addr = AW'(channel_position);

  assign base = cfg.channel_last ? mem_q : running_sum;
  assign sum = sp_zero ? x_hold : base + x_hold;

  assign push = (state == S_ADD) && last_s;
  assign push_entry.sum = sum;
  assign push_entry.chan = chan_hold[qgap_pkg::CHAN_OUT_W-1:0];
  assign push_entry.image_done = last_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      spatial_position <= '0;
      channel_position <= '0;
      running_sum <= '0;
    end else if (restart) begin
      state <= S_IDLE;
      spatial_position <= '0;
      channel_position <= '0;
      running_sum <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ADD;
            if (cfg.channel_last) begin
              if (last_c_now) begin
                channel_position <= '0;
                spatial_position <= last_s_now ? '0 : spatial_position + 24'd1;
              end else begin
                channel_position <= channel_position + 11'd1;
              end
            end else begin
              if (last_s_now) begin
                spatial_position <= '0;
                channel_position <= last_c_now ? '0 : channel_position + 11'd1;
              end else begin
                spatial_position <= spatial_position + 24'd1;
              end
            end
          end
        end
        S_ADD: begin
          state <= S_IDLE;
          if (!cfg.channel_last) begin
            running_sum <= last_s ? '0 : sum;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_hold <= x_ext;
      sp_zero <= (spatial_position == '0);
      last_s <= last_s_now;
      last_c <= last_c_now;
      chan_hold <= channel_position;
      addr_hold <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= sums[addr];
    end
    if ((state == S_ADD) && cfg.channel_last) begin
      sums[addr_hold] <= sum;
    end
  end

  a_accept_then_add: assert property (@(posedge clk) disable iff (rst || restart)
    accept |=> (state == S_ADD))
    else $error("Accepted sample was not followed by the accumulate cycle.");

endmodule

[hw/rtl/qgap_queue.sv]
// Short queue of finished channel sums between the front and the back part.
// Uses qgap_pkg for the entry type, depth and status struct.
module qgap_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  qgap_pkg::entry_t        push_entry,
  input  logic                    pop,
  output qgap_pkg::entry_t        head,
  output qgap_pkg::queue_status_t status
);

  localparam int DEPTH = qgap_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  qgap_pkg::entry_t entries [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [NW-1:0]    count;

  assign head = entries[rd_ptr];
  assign status.room = count < NW'(DEPTH);
  assign status.nonempty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < NW'(DEPTH)))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("Queue read while empty.");

endmodule

[hw/rtl/qgap_back.sv]
// Back part: divides each queued sum by the kernel size, one quotient bit per cycle.
// Uses qgap_pkg and qgap_result_if; holds the result in an output register.
module qgap_back (
  input  logic             clk,
  input  logic             rst,
  input  qgap_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  qgap_pkg::entry_t head,
  output logic             pop,
  qgap_result_if.source    results
);

  localparam int SW = qgap_pkg::SUM_W;
  localparam int KW = qgap_pkg::KERNEL_W;
  localparam int STW = $clog2(qgap_pkg::DIV_STEPS);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]                       state;
  logic [SW-1:0]                    dividend;
  logic [KW-1:0]                    rem;
  logic [STW-1:0]                   step;
  logic                             neg;
  logic [qgap_pkg::CHAN_OUT_W-1:0]  chan;
  logic                             done;

  logic [KW:0] trial;
  logic        qbit;
  logic        out_free;

  assign pop = (state == B_IDLE) && head_valid;
  assign trial = {rem, dividend[SW-1]};
  assign qbit = trial >= {1'b0, cfg.k};
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && (state != B_DONE)) begin
        results.valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (step == STW'(qgap_pkg::DIV_STEPS - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            results.valid <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          neg <= cfg.is_signed && head.sum[SW-1];
          dividend <= (cfg.is_signed && head.sum[SW-1]) ? (~head.sum + 32'd1) : head.sum;
          rem <= '0;
          step <= '0;
          chan <= head.chan;
          done <= head.image_done;
        end
      end
      B_DIV: begin
        rem <= qbit ? KW'(trial - {1'b0, cfg.k}) : trial[KW-1:0];
        dividend <= {dividend[SW-2:0], qbit};
        step <= step + STW'(1);
      end
      B_DONE: begin
        if (out_free) begin
          results.average <= neg ? (~dividend[7:0] + 8'd1) : dividend[7:0];
          results.channel_index <= chan;
          results.image_done <= done;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/quantized_global_average_pool_top.sv]
// Top level of the quantized global average pool: configuration registers and wiring.
// Depends on qgap_pkg, both channel interfaces, qgap_front, qgap_queue and qgap_back.

// The front part takes a sample and then spends an accumulate state on the
// read-modify-write of the per-channel sum memory (one read and one write port),
// so it takes no new sample until that is done, nor while the queue is full. Each
// average then passes through a two-entry queue into a shift-subtract divider
// that takes no new sum until its result is loaded into the output register.
// A write to one of the four configuration registers restarts the current image.
module quantized_global_average_pool_top #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [qgap_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qgap_pkg::CFG_DATA_W-1:0]      cfg_data,
  qgap_sample_if.sink                          samples,
  qgap_result_if.source                        results
);

  logic                              is_signed;
  logic                              channel_last;
  logic [qgap_pkg::CHANNELS_W-1:0]   channels;
  logic [qgap_pkg::KERNEL_W-1:0]     spatial_size;

  qgap_pkg::cfg_t          cfg;
  logic                    restart;
  logic                    push;
  qgap_pkg::entry_t        push_entry;
  logic                    pop;
  qgap_pkg::entry_t        head;
  qgap_pkg::queue_status_t qstatus;

  assign restart = cfg_write && (cfg_index == qgap_pkg::REG_IS_SIGNED ||
                                 cfg_index == qgap_pkg::REG_CHANNEL_LAST ||
                                 cfg_index == qgap_pkg::REG_CHANNELS ||
                                 cfg_index == qgap_pkg::REG_SPATIAL_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      is_signed <= 1'b0;
      channel_last <= 1'b0;
      channels <= 11'd1;
      spatial_size <= 25'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        qgap_pkg::REG_IS_SIGNED:    is_signed <= cfg_data[0];
        qgap_pkg::REG_CHANNEL_LAST: channel_last <= cfg_data[0];
        qgap_pkg::REG_CHANNELS:     channels <= cfg_data[qgap_pkg::CHANNELS_W-1:0];
        qgap_pkg::REG_SPATIAL_SIZE: spatial_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.is_signed = is_signed;
    cfg.channel_last = channel_last;
    if (channels == '0) begin
      cfg.nc = 11'd1;
    end else if (32'(channels) > 32'(MAX_CHANNELS)) begin
      cfg.nc = qgap_pkg::CHANNELS_W'(MAX_CHANNELS);
    end else begin
      cfg.nc = channels;
    end
    if (spatial_size == '0) begin
      cfg.k = 25'd1;
    end else if (spatial_size > qgap_pkg::KERNEL_LIMIT) begin
      cfg.k = qgap_pkg::KERNEL_LIMIT;
    end else begin
      cfg.k = spatial_size;
    end
  end

  qgap_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .restart(restart),
    .samples(samples),
    .queue_room(qstatus.room),
    .push(push),
    .push_entry(push_entry)
  );

  qgap_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .status(qstatus)
  );

  qgap_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head_valid(qstatus.nonempty),
    .head(head),
    .pop(pop),
    .results(results)
  );

endmodule

[sim/qgap_mean_checker.sv]
// Checker for the quantized global average pool: watches the register port and both channels,
// predicts every channel average from the accepted samples and compares it with the block.
// Depends on qgap_pkg and the two channel interfaces.
module qgap_mean_checker #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [qgap_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qgap_pkg::CFG_DATA_W-1:0]    cfg_data,
  qgap_sample_if                             samples,
  qgap_result_if                             results,
  output int                                 mismatch_count,
  output int                                 means_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import qgap_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   average;
    logic [CHAN_OUT_W-1:0] channel_index;
    logic                  image_done;
  } channel_mean_t;

  channel_mean_t means_due[$];

  logic                  signed_bytes;
  logic                  interleaved;
  logic [CHANNELS_W-1:0] channel_count;
  logic [KERNEL_W-1:0]   spatial_size;
  logic [SUM_W-1:0]      channel_acc[MAX_CHANNELS];
  logic [SUM_W-1:0]      run_acc;
  int unsigned           spatial_pos;
  int unsigned           chan_pos;

  function automatic logic [SAMPLE_W-1:0] truncated_mean(logic [SUM_W-1:0] sum, int unsigned k);
    longint quotient;
    if (signed_bytes) begin
      quotient = longint'($signed(sum)) / longint'(k);
    end else begin
      quotient = longint'(sum) / longint'(k);
    end
    return quotient[SAMPLE_W-1:0];
  endfunction

  task automatic start_image();
    run_acc = '0;
    spatial_pos = 0;
    chan_pos = 0;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    case (index)
      REG_IS_SIGNED: begin
        signed_bytes = value[0];
        start_image();
      end
      REG_CHANNEL_LAST: begin
        interleaved = value[0];
        start_image();
      end
      REG_CHANNELS: begin
        channel_count = value[CHANNELS_W-1:0];
        start_image();
      end
      REG_SPATIAL_SIZE: begin
        spatial_size = value[KERNEL_W-1:0];
        start_image();
      end
      default: ;
    endcase
  endtask

  task automatic accumulate_sample(logic [SAMPLE_W-1:0] raw);
    int unsigned      nc;
    int unsigned      k;
    int unsigned      c;
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] sum;
    logic             last_spatial;
    logic             last_channel;
    channel_mean_t    due;
    if (channel_count == 0) nc = 1;
    else if (channel_count > MAX_CHANNELS) nc = MAX_CHANNELS;
    else nc = channel_count;
    if (spatial_size == 0) k = 1;
    else if (spatial_size > KERNEL_LIMIT) k = KERNEL_LIMIT;
    else k = spatial_size;
    if (signed_bytes) begin
      x = SUM_W'($signed(raw));
    end else begin
      x = SUM_W'(raw);
    end
    c = (chan_pos >= nc) ? nc - 1 : chan_pos;
    last_spatial = spatial_pos >= k - 1;
    last_channel = c >= nc - 1;
    if (interleaved) begin
      sum = (spatial_pos == 0) ? x : channel_acc[c] + x;
      channel_acc[c] = sum;
      if (last_channel) begin
        chan_pos = 0;
        spatial_pos = last_spatial ? 0 : spatial_pos + 1;
      end else begin
        chan_pos = c + 1;
      end
    end else begin
      sum = (spatial_pos == 0) ? x : run_acc + x;
      run_acc = sum;
      if (last_spatial) begin
        spatial_pos = 0;
        run_acc = '0;
        chan_pos = last_channel ? 0 : c + 1;
      end else begin
        spatial_pos = spatial_pos + 1;
      end
    end
    if (last_spatial) begin
      due = '{truncated_mean(sum, k), c[CHAN_OUT_W-1:0], last_channel};
      means_due = {means_due, due};
    end
  endtask

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic compare_mean();
    channel_mean_t want;
    if (means_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected average %0h channel %0d image_done %0b",
                              results.average, results.channel_index, results.image_done));
    end else begin
      want = means_due.pop_front();
      if (results.average !== want.average || results.channel_index !== want.channel_index ||
          results.image_done !== want.image_done) begin
        flag_mismatch($sformatf({"average mismatch: expected %0h ch %0d done %0b, ",
                                 "got %0h ch %0d done %0b"},
                                want.average, want.channel_index, want.image_done,
                                results.average, results.channel_index, results.image_done));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      signed_bytes = 1'b0;
      interleaved = 1'b0;
      channel_count = CHANNELS_W'(1);
      spatial_size = KERNEL_W'(1);
      foreach (channel_acc[i]) channel_acc[i] = '0;
      start_image();
      means_due.delete();
    end else begin
      if (results.valid && results.ready) compare_mean();
      if (cfg_write) write_register(cfg_index, cfg_data);
      if (samples.valid && samples.ready) accumulate_sample(samples.sample);
    end
    means_outstanding <= means_due.size();
  end

endmodule

[sim/quantized_global_average_pool_top_tb.sv]
// Testbench top for the quantized global average pool: clock, reset, register writes, sample
// stimulus with bursts and gaps, a stalling result receiver and the final verdict.
// Depends on qgap_pkg, both channel interfaces, the block and qgap_mean_checker.
module quantized_global_average_pool_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qgap_pkg::*;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SWEEP_ITEMS   = 150;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef enum {
    READY_ALWAYS,
    READY_HALF,
    READY_MOSTLY,
    READY_RARELY,
    READY_ALTERNATE
  } ready_pattern_e;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatch_count;
  int                     means_outstanding;
  int                     hold_requests;
  int                     burst_left;
  int                     items_sent;
  bit                     gappy;
  bit                     uniform;
  logic [SAMPLE_W-1:0]    base;

  qgap_sample_if samples ();
  qgap_result_if results ();

  quantized_global_average_pool_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results)
  );

  qgap_mean_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .samples           (samples),
    .results           (results),
    .mismatch_count    (mismatch_count),
    .means_outstanding (means_outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push(input logic [SAMPLE_W-1:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gappy) begin
        samples.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    samples.valid <= 1'b1;
    samples.sample <= value;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) begin
      if (uniform && $urandom_range(0, 3) != 0) push(base);
      else push(random_sample());
    end
  endtask

  task automatic wait_until_drained();
    samples.valid <= 1'b0;
    do @(posedge clk); while (means_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_unlisted();
    write_reg(CFG_INDEX_W'($urandom_range(REG_SPATIAL_SIZE + 1, (1 << CFG_INDEX_W) - 1)),
              CFG_DATA_W'($urandom));
  endtask

  task automatic configure(input bit sgn, input bit last, input int unsigned nc,
                           input int unsigned k, input bit every, input bit unlisted);
    if (every || $urandom_range(0, 1)) begin
      write_reg(REG_IS_SIGNED, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(sgn));
    end
    if (every || $urandom_range(0, 1)) begin
      write_reg(REG_CHANNEL_LAST, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(last));
    end
    write_reg(REG_CHANNELS, CFG_DATA_W'(($urandom << CHANNELS_W) | nc));
    write_reg(REG_SPATIAL_SIZE, CFG_DATA_W'(k));
    if (unlisted) write_unlisted();
    end_writes();
  endtask

  initial begin : receiver
    ready_pattern_e pattern;
    int             pattern_left;
    int             hold_left;
    int             holds_served;
    results.ready <= 1'b0;
    pattern = READY_ALWAYS;
    pattern_left = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = ready_pattern_e'($urandom_range(0, 4));
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          READY_ALWAYS:    results.ready <= 1'b1;
          READY_HALF:      results.ready <= $urandom_range(0, 1) != 0;
          READY_MOSTLY:    results.ready <= $urandom_range(0, 3) != 0;
          READY_RARELY:    results.ready <= $urandom_range(0, 3) == 0;
          READY_ALTERNATE: results.ready <= (pattern_left % 4) < 2;
          default:         results.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned nc;
    int unsigned k;
    int unsigned image_len;
    int unsigned images;
    int          first_random;
    int          phase;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IS_SIGNED;
    cfg_data <= '0;
    samples.valid <= 1'b0;
    samples.sample <= '0;
    hold_requests <= 0;
    burst_left = 0;
    items_sent = 0;
    gappy = 1'b0;
    uniform = 1'b0;
    base = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: unsigned, channel-first, one channel, one element per channel.
    push(8'h00);
    push(8'hFF);
    push(8'h80);
    push(8'h7F);
    wait_until_drained();

    configure(1'b1, 1'b0, 2, 3, 1'b1, 1'b0);
    push(8'h80);
    push(8'h80);
    push(8'h80);
    push(8'hFF);
    push(8'h00);
    push(8'h00);
    wait_until_drained();

    configure(1'b0, 1'b1, 3, 2, 1'b1, 1'b0);
    push(8'hFF);
    push(8'h00);
    push(8'h01);
    push(8'hFF);
    push(8'hFF);
    push(8'h02);
    wait_until_drained();

    // A write outside the register list must not restart the image, a listed one must.
    configure(1'b0, 1'b0, 1, 2, 1'b1, 1'b0);
    push(8'h40);
    wait_until_drained();
    write_unlisted();
    end_writes();
    push(8'hC0);
    push(8'h05);
    wait_until_drained();
    write_reg(REG_IS_SIGNED, CFG_DATA_W'(1));
    end_writes();
    push(8'hFF);
    push(8'hFD);
    wait_until_drained();

    // Zero channels and zero kernel both act as one; oversized kernels clamp.
    configure(1'b1, 1'b0, 0, 0, 1'b1, 1'b0);
    push(8'h81);
    push(8'h01);
    wait_until_drained();
    write_reg(REG_SPATIAL_SIZE, {CFG_DATA_W{1'b1}});
    end_writes();
    push(8'h7F);
    push(8'h80);
    push(8'hFF);
    wait_until_drained();
    write_reg(REG_SPATIAL_SIZE, CFG_DATA_W'(KERNEL_LIMIT));
    end_writes();
    push(8'h01);
    push(8'hFE);
    wait_until_drained();

    // Oversized channel count clamps to the maximum; one average per sample.
    configure(1'($urandom_range(0, 1)), 1'b1, (1 << CHANNELS_W) - 1, 1, 1'b1, 1'b0);
    gappy = 1'b1;
    push_random(SWEEP_ITEMS);
    wait_until_drained();

    first_random = items_sent;
    phase = 0;
    while (items_sent - first_random < RANDOM_ITEMS || phase < 3) begin
      case ($urandom_range(0, 9))
        0:       nc = 0;
        1:       nc = $urandom_range(9, 40);
        default: nc = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       k = 0;
        1:       k = (nc <= 8) ? $urandom_range(9, 24) : $urandom_range(2, 4);
        default: k = $urandom_range(1, 8);
      endcase
      if (phase == 1) begin
        nc = $urandom_range(16, 40);
        k = 1;
      end
      configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), nc, k, phase == 0,
                $urandom_range(0, 7) == 0);
      gappy = (phase != 1) && ($urandom_range(0, 3) != 0);
      uniform = $urandom_range(0, 3) == 0;
      base = random_sample();
      if (phase == 1 || $urandom_range(0, 15) == 0) hold_requests <= hold_requests + 1;
      image_len = (nc == 0 ? 1 : nc) * (k == 0 ? 1 : k);
      images = (phase == 1) ? 2 : $urandom_range(1, 3);
      for (int i = 0; i < images; i++) begin
        push_random(image_len);
        if (i == 0 && images > 1 && (phase == 2 || $urandom_range(0, 3) == 0)) begin
          wait_until_drained();
        end
      end
      if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, image_len));
      wait_until_drained();
      phase++;
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && means_outstanding == 0) begin
      $display("[quantized_global_average_pool_top] OK");
    end else begin
      $display("[quantized_global_average_pool_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[quantized_global_average_pool_top] ERROR");
    $finish;
  end

endmodule
